/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the report tracker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define HSK_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsk assertion failed");

// next-cycle implication, checked while out of reset
`define HSK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsk assertion failed");

`endif

/* hw/rtl/hsk_pkg.sv */
// ----------------------------------------------------------------------------
// hsk_pkg
// shared types and constants of the six-key report tracker
// ----------------------------------------------------------------------------
package hsk_pkg;

    localparam int CODE_W      = 16;
    localparam int KEY_W       = 8;
    localparam int REPORT_KEYS = 6;

    // modifier usages occupy 0xe0 .. 0xe7
    localparam logic [4:0]       MOD_CODE_PREFIX = 5'b11100;
    localparam logic [KEY_W-1:0] KEY_NONE        = 8'h00;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic press;
        logic release_key;
    } key_op_t;

    typedef struct packed {
        logic [7:0]                  modifiers;
        key_t [REPORT_KEYS-1:0]      keys;
    } report_t;

endpackage

/* hw/rtl/hsk_key_slots.sv */
// ----------------------------------------------------------------------------
// hsk_key_slots
// next state of the packed key slot list for one press or release
// ----------------------------------------------------------------------------
module hsk_key_slots #(
    parameter int KEY_SLOTS = 6
) (
    input  hsk_pkg::key_t [KEY_SLOTS-1:0] slots_in,
    input  hsk_pkg::key_t                 code,
    input  hsk_pkg::key_op_t              op,
    output hsk_pkg::key_t [KEY_SLOTS-1:0] slots_out
);

    logic [KEY_SLOTS-1:0] match;
    logic [KEY_SLOTS-1:0] empty;
    logic [KEY_SLOTS-1:0] seen_match;
    logic [KEY_SLOTS-1:0] first_empty;
    logic                 any_match;

    always_comb begin
        logic seen_empty;
        seen_empty = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            match[i]       = (slots_in[i] == code);
            empty[i]       = (slots_in[i] == hsk_pkg::KEY_NONE);
            first_empty[i] = empty[i] && !seen_empty;
            seen_empty     = seen_empty || empty[i];
        end
        // slots at or after the first hit shift down on release
        seen_match[0] = match[0];
        for (int i = 1; i < KEY_SLOTS; i++) begin
            seen_match[i] = seen_match[i-1] || match[i];
        end
        any_match = seen_match[KEY_SLOTS-1];
    end

    always_comb begin
        slots_out = slots_in;
        if (op.press && !any_match) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (first_empty[i]) begin
                    slots_out[i] = code;
                end
            end
        end else if (op.release_key) begin
            for (int i = 0; i < KEY_SLOTS - 1; i++) begin
                if (seen_match[i]) begin
                    slots_out[i] = slots_in[i+1];
                end
            end
            if (any_match) begin
                slots_out[KEY_SLOTS-1] = hsk_pkg::KEY_NONE;
            end
        end
    end

endmodule

/* hw/rtl/hsk_out_stage.sv */
// ----------------------------------------------------------------------------
// hsk_out_stage
// result register holding one report until the receiver takes it
// ----------------------------------------------------------------------------
module hsk_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  hsk_pkg::report_t  report_in,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output hsk_pkg::report_t  report_out
);

    logic             valid_reg;
    logic             valid_next;
    hsk_pkg::report_t report_reg;

    assign free       = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign report_out = report_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            report_reg <= report_in;
        end
    end

endmodule

/* hw/rtl/hid_six_key_report_tracker_unit.sv */
// ----------------------------------------------------------------------------
// hid_six_key_report_tracker_unit
// boot keyboard report tracker: modifier byte plus packed key slots
// ----------------------------------------------------------------------------
// s_ channel takes key events (16-bit key code, press or release); m_ channel
// gives the full report (modifier byte, six key slots). cfg_wr_en/cfg_wr_data
// write link_enabled; with it low the state still tracks events but no
// report is sent. Codes above 0xff are dropped with no report, 0xe0..0xe7
// set or clear a modifier bit, code zero just resends the report, other
// codes add to or remove from the packed slot list.
// Timing: an event sits in the input register, where the slot update and the
// report load are done; the report is then registered in the result register
// and shows on m_valid. One event per cycle sustained while the result
// register is free, set by the slot compare/shift path, which reads the state
// left by the previous event.
// Reset and stall: reset empties all slots, clears the modifiers, sets
// link_enabled and drops any event or report in flight. While m_ready is
// low the report holds and one more event waits in the input register,
// which then holds s_ready low; events that give no report never wait on m_.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_six_key_report_tracker_unit #(
    parameter int KEY_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_key_code,
    input  logic        s_is_press,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_modifier_byte,
    output logic [7:0]  m_key_slot_0,
    output logic [7:0]  m_key_slot_1,
    output logic [7:0]  m_key_slot_2,
    output logic [7:0]  m_key_slot_3,
    output logic [7:0]  m_key_slot_4,
    output logic [7:0]  m_key_slot_5
);

    // input register
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [hsk_pkg::CODE_W-1:0]       in_code_reg;
    logic                             in_press_reg;

    // tracked state
    logic                             link_enabled_reg;
    logic [7:0]                       mods_reg;
    logic [7:0]                       mods_next;
    hsk_pkg::key_t [KEY_SLOTS-1:0]    slots_reg;
    hsk_pkg::key_t [KEY_SLOTS-1:0]    slots_next;

    // event decode
    hsk_pkg::key_t                    code_lo;
    logic                             in_range;
    logic                             is_mod;
    logic                             is_key;
    logic [7:0]                       mod_bit;
    hsk_pkg::key_op_t                 key_op;

    logic                             produces;
    logic                             advance;
    logic                             out_free;
    hsk_pkg::report_t                 report_next;
    hsk_pkg::report_t                 report_out;

    assign code_lo  = in_code_reg[hsk_pkg::KEY_W-1:0];
    assign in_range = (in_code_reg[hsk_pkg::CODE_W-1:hsk_pkg::KEY_W] == '0);
    assign is_mod   = in_range && (code_lo[7:3] == hsk_pkg::MOD_CODE_PREFIX);
    assign is_key   = in_range && !is_mod && (code_lo != hsk_pkg::KEY_NONE);
    assign mod_bit  = 8'h01 << code_lo[2:0];

    assign key_op.press       = is_key && in_press_reg;
    assign key_op.release_key = is_key && !in_press_reg;

    // dropped codes and link-off events never wait on the result register
    assign produces = in_range && link_enabled_reg;
    assign advance  = in_valid_reg && (!produces || out_free);
    assign s_ready  = !in_valid_reg || advance;

    hsk_key_slots #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_key_slots (
        .slots_in  (slots_reg),
        .code      (code_lo),
        .op        (key_op),
        .slots_out (slots_next)
    );

    always_comb begin
        mods_next = mods_reg;
        if (is_mod) begin
            if (in_press_reg) begin
                mods_next = mods_reg | mod_bit;
            end else begin
                mods_next = mods_reg & ~mod_bit;
            end
        end
    end

    // report view: slots past the sixth are not reported, missing ones read 0
    assign report_next.modifiers = mods_next;
    for (genvar g = 0; g < hsk_pkg::REPORT_KEYS; g++) begin : g_report
        if (g < KEY_SLOTS) begin : g_slot
            assign report_next.keys[g] = slots_next[g];
        end else begin : g_none
            assign report_next.keys[g] = hsk_pkg::KEY_NONE;
        end
    end

    hsk_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && produces),
        .report_in  (report_next),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .report_out (report_out)
    );

    assign m_modifier_byte = report_out.modifiers;
    assign m_key_slot_0    = report_out.keys[0];
    assign m_key_slot_1    = report_out.keys[1];
    assign m_key_slot_2    = report_out.keys[2];
    assign m_key_slot_3    = report_out.keys[3];
    assign m_key_slot_4    = report_out.keys[4];
    assign m_key_slot_5    = report_out.keys[5];

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            link_enabled_reg <= 1'b1;
            mods_reg         <= '0;
            slots_reg        <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                link_enabled_reg <= cfg_wr_data;
            end
            if (advance) begin
                mods_reg  <= mods_next;
                slots_reg <= slots_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_code_reg  <= s_key_code;
            in_press_reg <= s_is_press;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a held event waits for the blocked result register without changing
    `HSK_ASSERT_NEXT(a_event_holds, aclk, aresetn,
        in_valid_reg && produces && m_valid && !m_ready,
        in_valid_reg && $stable(in_code_reg) && $stable(in_press_reg))

    // an event that gives no report never raises a result
    `HSK_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn,
        advance && !produces && !(m_valid && !m_ready), !m_valid)

    // modifier events leave the slot list alone
    `HSK_ASSERT_NEXT(a_mod_keeps_slots, aclk, aresetn,
        advance && is_mod, $stable(slots_reg))

    // nonzero keys stay packed at the low slots
    for (genvar p = 0; p + 1 < KEY_SLOTS; p++) begin : g_packed_chk
        `HSK_ASSERT_NOW(a_slots_packed, aclk, aresetn,
            slots_reg[p] == hsk_pkg::KEY_NONE, slots_reg[p+1] == hsk_pkg::KEY_NONE)
    end

endmodule

/* verif/key_report_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_report_checker
// tracks the held modifiers and key slots from every key event transfer,
// queues the report each one should produce and compares it field by field
// with the reports leaving the tracker
// ----------------------------------------------------------------------------
module key_report_checker (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [hsk_pkg::CODE_W-1:0] s_key_code,
    input  logic                       s_is_press,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [7:0]                 m_modifier_byte,
    input  logic [7:0]                 m_key_slot_0,
    input  logic [7:0]                 m_key_slot_1,
    input  logic [7:0]                 m_key_slot_2,
    input  logic [7:0]                 m_key_slot_3,
    input  logic [7:0]                 m_key_slot_4,
    input  logic [7:0]                 m_key_slot_5,

    output int                         fail_count,
    output int                         pending_reports
);

    logic [7:0]       held_mods;
    hsk_pkg::key_t    held_keys [hsk_pkg::REPORT_KEYS];
    logic             link_on;
    hsk_pkg::report_t expected_reports [$];
    int               report_idx;

    // updates the held state for one event and returns the resulting report
    function automatic hsk_pkg::report_t apply_key_event(
        input logic [hsk_pkg::CODE_W-1:0] code,
        input logic                       press);
        hsk_pkg::report_t rpt;
        int               hit;
        hit = -1;
        if (code[7:3] == hsk_pkg::MOD_CODE_PREFIX) begin
            held_mods[code[2:0]] = press;
        end else if (code[7:0] != hsk_pkg::KEY_NONE) begin
            for (int i = 0; i < hsk_pkg::REPORT_KEYS; i++) begin
                if (hit < 0 && held_keys[i] == code[7:0]) begin
                    hit = i;
                end
            end
            if (press) begin
                // already held keys stay put, full slots drop the key
                if (hit < 0) begin
                    for (int i = 0; i < hsk_pkg::REPORT_KEYS; i++) begin
                        if (hit < 0 && held_keys[i] == hsk_pkg::KEY_NONE) begin
                            held_keys[i] = code[7:0];
                            hit = i;
                        end
                    end
                end
            end else if (hit >= 0) begin
                for (int j = hit; j < hsk_pkg::REPORT_KEYS - 1; j++) begin
                    held_keys[j] = held_keys[j + 1];
                end
                held_keys[hsk_pkg::REPORT_KEYS - 1] = hsk_pkg::KEY_NONE;
            end
        end
        rpt.modifiers = held_mods;
        for (int i = 0; i < hsk_pkg::REPORT_KEYS; i++) begin
            rpt.keys[i] = held_keys[i];
        end
        return rpt;
    endfunction

    always @(posedge aclk) begin : watch
        hsk_pkg::report_t got;
        hsk_pkg::report_t want;
        logic             bad;
        if (!aresetn) begin
            held_mods = '0;
            foreach (held_keys[i]) begin
                held_keys[i] = hsk_pkg::KEY_NONE;
            end
            link_on = 1'b1;
            expected_reports.delete();
            fail_count = 0;
            report_idx = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.modifiers = m_modifier_byte;
                got.keys[0]   = m_key_slot_0;
                got.keys[1]   = m_key_slot_1;
                got.keys[2]   = m_key_slot_2;
                got.keys[3]   = m_key_slot_3;
                got.keys[4]   = m_key_slot_4;
                got.keys[5]   = m_key_slot_5;
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("report %0d: transfer with no report expected, mod %02h",
                                 report_idx, got.modifiers);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    bad  = (got.modifiers !== want.modifiers);
                    for (int i = 0; i < hsk_pkg::REPORT_KEYS; i++) begin
                        bad |= (got.keys[i] !== want.keys[i]);
                    end
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"report %0d: expected mod %02h keys %02h %02h %02h",
                                      " %02h %02h %02h, got mod %02h keys %02h %02h %02h",
                                      " %02h %02h %02h"},
                                     report_idx, want.modifiers,
                                     want.keys[0], want.keys[1], want.keys[2],
                                     want.keys[3], want.keys[4], want.keys[5],
                                     got.modifiers,
                                     got.keys[0], got.keys[1], got.keys[2],
                                     got.keys[3], got.keys[4], got.keys[5]);
                        end
                    end
                end
                report_idx++;
            end
            if (cfg_wr_en) begin
                link_on = cfg_wr_data;
            end
            // layer and custom codes above one byte leave no trace
            if (s_valid && s_ready && s_key_code[hsk_pkg::CODE_W-1:8] == '0) begin
                want = apply_key_event(s_key_code, s_is_press);
                if (link_on) begin
                    expected_reports.push_back(want);
                end
            end
        end
        pending_reports = expected_reports.size();
    end

endmodule

/* verif/hid_six_key_report_tracker_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hid_six_key_report_tracker_unit_test
// drives key press and release events into the report tracker with random
// gaps and output stalls, toggles the link enable between phases and takes
// the verdict from the report checker
// ----------------------------------------------------------------------------
module hid_six_key_report_tracker_unit_test;

    typedef logic [hsk_pkg::CODE_W-1:0] code_t;

    localparam logic  EV_PRESS         = 1'b1;
    localparam logic  EV_RELEASE       = 1'b0;
    localparam code_t CODE_NONE        = 16'h0000;
    localparam code_t KEY_A            = 16'h0004;
    localparam code_t USAGE_BELOW_MODS = 16'h00DF;
    localparam code_t MOD_LEFT_CTRL    = 16'h00E0;
    localparam code_t MOD_RIGHT_GUI    = 16'h00E7;
    localparam code_t USAGE_ABOVE_MODS = 16'h00E8;
    localparam code_t USAGE_TOP        = 16'h00FF;
    localparam code_t CODE_LAYER_FIRST = 16'h0100;
    localparam code_t CODE_ALL_ONES    = 16'hFFFF;
    localparam int    SETTLE_CYCLES    = 8;
    localparam int    LONG_HOLD_CYCLES = 300;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    code_t      s_key_code;
    logic       s_is_press;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_modifier_byte;
    logic [7:0] m_key_slot_0;
    logic [7:0] m_key_slot_1;
    logic [7:0] m_key_slot_2;
    logic [7:0] m_key_slot_3;
    logic [7:0] m_key_slot_4;
    logic [7:0] m_key_slot_5;

    int fail_count;
    int pending_reports;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    hid_six_key_report_tracker_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_code      (s_key_code),
        .s_is_press      (s_is_press),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifier_byte (m_modifier_byte),
        .m_key_slot_0    (m_key_slot_0),
        .m_key_slot_1    (m_key_slot_1),
        .m_key_slot_2    (m_key_slot_2),
        .m_key_slot_3    (m_key_slot_3),
        .m_key_slot_4    (m_key_slot_4),
        .m_key_slot_5    (m_key_slot_5)
    );

    key_report_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_code      (s_key_code),
        .s_is_press      (s_is_press),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifier_byte (m_modifier_byte),
        .m_key_slot_0    (m_key_slot_0),
        .m_key_slot_1    (m_key_slot_1),
        .m_key_slot_2    (m_key_slot_2),
        .m_key_slot_3    (m_key_slot_3),
        .m_key_slot_4    (m_key_slot_4),
        .m_key_slot_5    (m_key_slot_5),
        .fail_count      (fail_count),
        .pending_reports (pending_reports)
    );

    // called at a falling edge; returns at the falling edge after the transfer
    // with valid still up, so the next call or stop_events must follow at once
    task automatic send_key_event(input code_t code, input logic press);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_code <= code;
        s_is_press <= press;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic stop_events();
        s_valid <= 1'b0;
        while (pending_reports != 0) begin
            @(negedge aclk);
        end
        // events with no report may still be in flight
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_link(input logic enable);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enable;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly a small pool of keys so slots fill up and releases hit held keys
    task automatic random_key_event();
        int    pick;
        code_t code;
        logic  press;
        pick  = int'($urandom_range(99));
        press = ($urandom_range(1) != 0);
        if (pick < 8) begin
            code = code_t'($urandom_range(16'hFFFF, 16'h0100));
        end else if (pick < 13) begin
            code = CODE_NONE;
        end else if (pick < 30) begin
            code = code_t'(MOD_LEFT_CTRL + $urandom_range(7));
        end else if (pick < 90) begin
            code  = code_t'(KEY_A + $urandom_range(9));
            press = ($urandom_range(99) < 55);
        end else begin
            code = code_t'($urandom_range(16'h00FF, 16'h0001));
        end
        send_key_event(code, press);
    endtask

    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_valid       = 1'b0;
        s_key_code    = CODE_NONE;
        s_is_press    = EV_RELEASE;
        send_idle_pct = 10;
        recv_idle_pct = 88;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_link(1'b1);

        // directed: empty report, modifiers, full slots, duplicates, packing
        send_key_event(CODE_NONE, EV_PRESS);
        send_key_event(MOD_LEFT_CTRL, EV_PRESS);
        send_key_event(MOD_RIGHT_GUI, EV_PRESS);
        send_key_event(MOD_LEFT_CTRL, EV_RELEASE);
        for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
            send_key_event(code_t'(KEY_A + k), EV_PRESS);
        end
        send_key_event(code_t'(KEY_A + 6), EV_PRESS);
        send_key_event(code_t'(KEY_A + 2), EV_PRESS);
        send_key_event(code_t'(KEY_A + 1), EV_RELEASE);
        send_key_event(code_t'(KEY_A + 7), EV_RELEASE);
        send_key_event(code_t'(KEY_A + 5), EV_RELEASE);
        send_key_event(USAGE_TOP, EV_PRESS);
        send_key_event(KEY_A, EV_RELEASE);
        send_key_event(CODE_ALL_ONES, EV_PRESS);
        send_key_event(CODE_LAYER_FIRST, EV_RELEASE);
        send_key_event(CODE_NONE, EV_RELEASE);
        send_key_event(MOD_RIGHT_GUI, EV_RELEASE);
        send_key_event(USAGE_BELOW_MODS, EV_PRESS);
        send_key_event(USAGE_ABOVE_MODS, EV_PRESS);
        stop_events();

        // link down: state keeps tracking, nothing comes out
        set_link(1'b0);
        send_idle_pct = 10;
        recv_idle_pct = 88;
        repeat (100) random_key_event();
        stop_events();
        set_link(1'b1);
        repeat (330) random_key_event();

        send_idle_pct = 88;
        recv_idle_pct = 10;
        repeat (330) random_key_event();
        stop_events();
        set_link(1'b0);
        repeat (40) random_key_event();
        stop_events();
        set_link(1'b1);

        // no idling, with one long output stall to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (330) random_key_event();
        stop_events();

        if (fail_count == 0 && pending_reports == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
